// File: rtl/lcs_pkg.sv
package lcs_pkg;

    localparam int MAX_LEN_DEFAULT = 32;
    localparam int SYMBOL_W        = 8;
    localparam int LENGTH_W        = 6;

    typedef enum logic [1:0] {
        CMD_APPEND_S = 2'd0,
        CMD_APPEND_T = 2'd1,
        CMD_START    = 2'd2
    } command_t;

    typedef struct packed {
        logic [1:0]          command;
        logic [SYMBOL_W-1:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] out_symbol;
        logic                symbol_valid;
        logic [LENGTH_W-1:0] seq_length;
        logic                last;
        logic                overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILL_RD,
        ST_FILL_WR,
        ST_TB_INIT,
        ST_TB_CHK,
        ST_TB_RD,
        ST_TB_STEP,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_EMPTY_OUT
    } state_t;

    typedef struct packed {
        logic load_s;
        logic load_t;
        logic fill_init;
        logic fill_wr;
        logic tb_init;
        logic tb_step;
        logic emit_init;
        logic emit_out;
        logic emit_empty;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_last;
        logic tb_done;
        logic n_zero;
        logic emit_last;
    } dp_status_t;

endpackage

// File: rtl/lcs_table_and_traceback_unit.sv
// longest common subsequence unit. a transaction is taken at a clock edge with start high and
// busy low. append commands load one symbol of S or T in that single cycle and busy stays low,
// so loads can run back to back; symbols past MAX_LEN are dropped and reported in the overflow
// bit of the next run. a start command raises busy and runs three phases over the on-chip
// length table: the fill reads and writes each of the (|S|+1)*(|T|+1) cells, bounded by the
// single table write port and its registered read; a traceback step checks, reads and moves, at
// most |S|+|T| steps; emission reads and outputs each LCS symbol. results leave on the result
// port one per strobe, in forward order, with last set on the final one; an empty LCS gives a
// single result with symbol_valid low. the receiver cannot stall: each result is on the port
// for exactly one cycle and must be captured then. busy drops in the cycle the last strobe is
// shown, and both strings and the overflow flag are cleared for the next run
module lcs_table_and_traceback_unit
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      strobe,
    output out_item_t result
);

    // command and status between sequencer and datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer: load, fill, traceback, emit
    lcs_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    // string stores, length table, result store and output register
    lcs_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .symbol (item.symbol),
        .cmd    (cmd),
        .status (status),
        .strobe (strobe),
        .result (result)
    );

endmodule

// File: rtl/lcs_ctrl.sv
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (command == CMD_START))
                begin
                    state_next = ST_FILL_RD;
                end
            end
            ST_FILL_RD:   state_next = ST_FILL_WR;
            ST_FILL_WR:   state_next = status.fill_last ? ST_TB_INIT : ST_FILL_RD;
            ST_TB_INIT:   state_next = ST_TB_CHK;
            ST_TB_CHK:
            begin
                if (!status.tb_done)
                begin
                    state_next = ST_TB_RD;
                end
                else if (status.n_zero)
                begin
                    state_next = ST_EMPTY_OUT;
                end
                else
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_TB_RD:     state_next = ST_TB_STEP;
            ST_TB_STEP:   state_next = ST_TB_CHK;
            ST_EMIT_RD:   state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:  state_next = status.emit_last ? ST_IDLE : ST_EMIT_RD;
            ST_EMPTY_OUT: state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_s    = (command == CMD_APPEND_S);
                    cmd.load_t    = (command == CMD_APPEND_T);
                    cmd.fill_init = (command == CMD_START);
                end
            end
            ST_FILL_WR:   cmd.fill_wr = 1'b1;
            ST_TB_INIT:   cmd.tb_init = 1'b1;
            ST_TB_CHK:    cmd.emit_init = status.tb_done;
            ST_TB_STEP:   cmd.tb_step = 1'b1;
            ST_EMIT_OUT:
            begin
                cmd.emit_out = 1'b1;
                cmd.clear    = status.emit_last;
            end
            ST_EMPTY_OUT:
            begin
                cmd.emit_empty = 1'b1;
                cmd.clear      = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/lcs_datapath.sv
module lcs_datapath
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [SYMBOL_W-1:0] symbol,
    input  ctrl_cmd_t           cmd,
    output dp_status_t          status,
    output logic                strobe,
    output out_item_t           result
);

    localparam int DIM       = MAX_LEN + 1;
    localparam int TBL_DEPTH = DIM * DIM;
    localparam int TA_W      = $clog2(TBL_DEPTH);
    localparam int CNT_W     = $clog2(MAX_LEN + 1);
    localparam int IDX_W     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // memories
    logic [SYMBOL_W-1:0] s_mem [MAX_LEN];
    logic [SYMBOL_W-1:0] t_mem [MAX_LEN];
    logic [SYMBOL_W-1:0] res_mem [MAX_LEN];
    logic [CNT_W-1:0]    tbl_mem [TBL_DEPTH];

    logic [SYMBOL_W-1:0] s_rd_reg;
    logic [SYMBOL_W-1:0] t_rd_reg;
    logic [SYMBOL_W-1:0] res_rd_reg;
    logic [CNT_W-1:0]    left_rd_reg;
    logic [CNT_W-1:0]    up_rd_reg;

    // control counters
    logic [CNT_W-1:0] s_count_reg;
    logic [CNT_W-1:0] t_count_reg;
    logic             drop_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] k_reg;
    logic             strobe_reg;

    // payload registers
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] diag_reg;
    out_item_t        result_reg;

    logic [TA_W-1:0]  addr_cur;
    logic [TA_W-1:0]  addr_left;
    logic [TA_W-1:0]  addr_up;
    logic [IDX_W-1:0] s_addr;
    logic [IDX_W-1:0] t_addr;
    logic [IDX_W-1:0] res_addr;
    logic [CNT_W-1:0] res_pos;
    logic             match;
    logic [CNT_W-1:0] cell_val;

    always_comb
    begin
        addr_cur  = TA_W'(i_reg) * TA_W'(DIM) + TA_W'(j_reg);
        addr_left = addr_cur - TA_W'(1);
        addr_up   = addr_cur - TA_W'(DIM);
        s_addr    = IDX_W'(i_reg - CNT_W'(1));
        t_addr    = IDX_W'(j_reg - CNT_W'(1));
        res_pos   = n_reg - CNT_W'(1) - k_reg;
        res_addr  = res_pos[IDX_W-1:0];
        match     = (s_rd_reg == t_rd_reg);
    end

    // recurrence for the cell at (i, j)
    always_comb
    begin
        if ((i_reg == '0) || (j_reg == '0))
        begin
            cell_val = '0;
        end
        else if (match)
        begin
            cell_val = diag_reg + CNT_W'(1);
        end
        else
        begin
            cell_val = (left_reg > up_rd_reg) ? left_reg : up_rd_reg;
        end
    end

    always_comb
    begin
        status.fill_last = (i_reg == s_count_reg) && (j_reg == t_count_reg);
        status.tb_done   = (i_reg == '0) || (j_reg == '0);
        status.n_zero    = (n_reg == '0);
        status.emit_last = (k_reg == n_reg - CNT_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_s && (s_count_reg < CNT_W'(MAX_LEN)))
        begin
            s_mem[s_count_reg[IDX_W-1:0]] <= symbol;
        end
        if (cmd.load_t && (t_count_reg < CNT_W'(MAX_LEN)))
        begin
            t_mem[t_count_reg[IDX_W-1:0]] <= symbol;
        end
        if (cmd.fill_wr)
        begin
            tbl_mem[addr_cur] <= cell_val;
        end
        if (cmd.tb_step && match)
        begin
            res_mem[n_reg[IDX_W-1:0]] <= s_rd_reg;
        end
        s_rd_reg    <= s_mem[s_addr];
        t_rd_reg    <= t_mem[t_addr];
        res_rd_reg  <= res_mem[res_addr];
        left_rd_reg <= tbl_mem[addr_left];
        up_rd_reg   <= tbl_mem[addr_up];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            left_reg <= cell_val;
            diag_reg <= (i_reg == '0) ? '0 : up_rd_reg;
        end
        if (cmd.emit_out)
        begin
            result_reg.out_symbol   <= res_rd_reg;
            result_reg.symbol_valid <= 1'b1;
            result_reg.seq_length   <= LENGTH_W'(n_reg);
            result_reg.last         <= status.emit_last;
            result_reg.overflow     <= drop_reg;
        end
        else if (cmd.emit_empty)
        begin
            result_reg.out_symbol   <= '0;
            result_reg.symbol_valid <= 1'b0;
            result_reg.seq_length   <= '0;
            result_reg.last         <= 1'b1;
            result_reg.overflow     <= drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_count_reg <= '0;
            t_count_reg <= '0;
            drop_reg    <= 1'b0;
            i_reg       <= '0;
            j_reg       <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit_out || cmd.emit_empty;
            if (cmd.load_s)
            begin
                if (s_count_reg < CNT_W'(MAX_LEN))
                begin
                    s_count_reg <= s_count_reg + CNT_W'(1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.load_t)
            begin
                if (t_count_reg < CNT_W'(MAX_LEN))
                begin
                    t_count_reg <= t_count_reg + CNT_W'(1);
                end
                else
                begin
                    drop_reg <= 1'b1;
                end
            end
            if (cmd.fill_init)
            begin
                i_reg <= '0;
                j_reg <= '0;
                n_reg <= '0;
            end
            if (cmd.fill_wr)
            begin
                if (j_reg == t_count_reg)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + CNT_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + CNT_W'(1);
                end
            end
            if (cmd.tb_init)
            begin
                i_reg <= s_count_reg;
                j_reg <= t_count_reg;
            end
            if (cmd.tb_step)
            begin
                if (match)
                begin
                    n_reg <= n_reg + CNT_W'(1);
                    i_reg <= i_reg - CNT_W'(1);
                    j_reg <= j_reg - CNT_W'(1);
                end
                else if (left_rd_reg > up_rd_reg)
                begin
                    j_reg <= j_reg - CNT_W'(1);
                end
                else
                begin
                    i_reg <= i_reg - CNT_W'(1);
                end
            end
            if (cmd.emit_init)
            begin
                k_reg <= '0;
            end
            if (cmd.emit_out)
            begin
                k_reg <= k_reg + CNT_W'(1);
            end
            if (cmd.clear)
            begin
                s_count_reg <= '0;
                t_count_reg <= '0;
                drop_reg    <= 1'b0;
            end
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
